/* rtl/sat_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sat_pkg
// Shared beat types, command opcodes, register indexes and back-end states
// for the summed-area table block.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int unsigned ValueW  = 24;
  localparam int unsigned BoundW  = 16;
  localparam int unsigned SumW    = 40;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 9;

  localparam logic [CfgIdxW-1:0] CFG_COLS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROWS = 2'd1;

  localparam logic [CfgW-1:0] CFG_COUNT_RST = 9'd256;

  typedef struct packed {
    logic                     kind;
    logic                     start_of_grid;
    logic signed [ValueW-1:0] value;
    logic signed [BoundW-1:0] first_col;
    logic signed [BoundW-1:0] last_col;
    logic signed [BoundW-1:0] first_row;
    logic signed [BoundW-1:0] last_row;
  } sat_in_t;

  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic                   not_ready;
  } sat_out_t;

  // input kind codes
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_EMPTY
  } cmd_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_WR,
    ST_Q_RD1,
    ST_Q_RD2,
    ST_Q_RD3,
    ST_Q_SUM,
    ST_Q_OUT
  } sat_state_e;

endpackage
`default_nettype wire

/* rtl/sat_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sat_cmd_fifo
// Small register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sat_cmd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  valid_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == NW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/sat_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sat_front
// Accepts beats, tracks the load position and row running sum, clamps query
// bounds and turns every beat into one back-end command.
// ----------------------------------------------------------------------------
module sat_front #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned CW       = $clog2(MAX_COLS),
  parameter int unsigned RW       = $clog2(MAX_ROWS),
  parameter int unsigned RSW      = sat_pkg::ValueW + CW,
  parameter int unsigned CMD_W    = 2 + 2 * CW + 2 * RW + 2 + RSW
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire logic                          full_i,
  input  wire sat_pkg::sat_in_t              in_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [sat_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sat_pkg::CfgW-1:0]      cfg_data_i,
  output logic                               cmd_push_o,
  output logic [CMD_W-1:0]                   cmd_o
);

  import sat_pkg::*;

  typedef struct packed {
    cmd_op_e        op;
    logic [CW-1:0]  col_a;
    logic [RW-1:0]  row_a;
    logic [CW-1:0]  col_b;
    logic [RW-1:0]  row_b;
    logic           use_col_b;
    logic           use_row_b;
    logic [RSW-1:0] rs;
  } cmd_t;

  logic [CfgW-1:0] cols_q, cols_d, rows_q, rows_d;
  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  logic [RSW-1:0]  rs_q, rs_d;
  logic            ready_q, ready_d;

  logic [CW-1:0]   last_col;
  logic [RW-1:0]   last_row;
  logic [CW-1:0]   c;
  logic [RW-1:0]   r;
  logic            restart;
  logic [RSW-1:0]  rs_new;
  logic [CW-1:0]   fc, lc;
  logic [RW-1:0]   fr, lr;
  logic            accept;
  cmd_t            cmd;

  function automatic logic [BoundW-1:0] clamp_idx(logic signed [BoundW-1:0] v,
                                                   logic [BoundW-1:0] last);
    if (v < 0) begin
      return '0;
    end else if (v > $signed(last)) begin
      return last;
    end
    return v;
  endfunction

  // a count of zero acts as one, a count above the maximum as the maximum
  always_comb begin
    if (cols_q == '0) begin
      last_col = '0;
    end else if (int'(cols_q) > MAX_COLS) begin
      last_col = CW'(MAX_COLS - 1);
    end else begin
      last_col = CW'(cols_q - 9'd1);
    end
    if (rows_q == '0) begin
      last_row = '0;
    end else if (int'(rows_q) > MAX_ROWS) begin
      last_row = RW'(MAX_ROWS - 1);
    end else begin
      last_row = RW'(rows_q - 9'd1);
    end
  end

  assign accept     = push_i && !full_i;
  assign cmd_push_o = accept;
  assign cmd_o      = cmd;

  assign restart = in_i.start_of_grid || (col_q > last_col) || (row_q > last_row);
  assign c       = restart ? '0 : col_q;
  assign r       = restart ? '0 : row_q;
  assign rs_new  = ((c == '0) ? '0 : rs_q)
                 + {{(RSW - ValueW){in_i.value[ValueW-1]}}, in_i.value};

  assign fc = CW'(clamp_idx(in_i.first_col, BoundW'(last_col)));
  assign lc = CW'(clamp_idx(in_i.last_col,  BoundW'(last_col)));
  assign fr = RW'(clamp_idx(in_i.first_row, BoundW'(last_row)));
  assign lr = RW'(clamp_idx(in_i.last_row,  BoundW'(last_row)));

  always_comb begin
    cmd = '0;
    if (in_i.kind == KIND_LOAD) begin
      cmd.op        = CMD_LOAD;
      cmd.col_a     = c;
      cmd.row_a     = r;
      cmd.col_b     = c;
      cmd.row_b     = r - 1'b1;
      cmd.use_row_b = (r != '0);
      cmd.rs        = rs_new;
    end else begin
      cmd.op        = ready_q ? CMD_QUERY : CMD_EMPTY;
      cmd.col_a     = lc;
      cmd.row_a     = lr;
      cmd.col_b     = fc - 1'b1;
      cmd.row_b     = fr - 1'b1;
      cmd.use_col_b = (fc != '0);
      cmd.use_row_b = (fr != '0);
    end
  end

  always_comb begin
    cols_d  = cols_q;
    rows_d  = rows_q;
    col_d   = col_q;
    row_d   = row_q;
    rs_d    = rs_q;
    ready_d = ready_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_COLS || cfg_idx_i == CFG_ROWS) begin
        if (cfg_idx_i == CFG_COLS) begin
          cols_d = cfg_data_i;
        end else begin
          rows_d = cfg_data_i;
        end
        col_d   = '0;
        row_d   = '0;
        rs_d    = '0;
        ready_d = 1'b0;
      end
    end else if (accept && in_i.kind == KIND_LOAD) begin
      rs_d = rs_new;
      if (c == '0 && r == '0) begin
        ready_d = 1'b0;
      end
      if (c == last_col) begin
        col_d = '0;
        if (r == last_row) begin
          row_d   = '0;
          ready_d = 1'b1;
        end else begin
          row_d = r + 1'b1;
        end
      end else begin
        col_d = c + 1'b1;
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= CFG_COUNT_RST;
      rows_q  <= CFG_COUNT_RST;
      col_q   <= '0;
      row_q   <= '0;
      rs_q    <= '0;
      ready_q <= 1'b0;
    end else begin
      cols_q  <= cols_d;
      rows_q  <= rows_d;
      col_q   <= col_d;
      row_q   <= row_d;
      rs_q    <= rs_d;
      ready_q <= ready_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/sat_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sat_back
// Executes commands against the single-port table memory: read-above then
// write for loads, four reads and an accumulate for queries. Holds the
// result register.
// ----------------------------------------------------------------------------
module sat_back #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned CW       = $clog2(MAX_COLS),
  parameter int unsigned RW       = $clog2(MAX_ROWS),
  parameter int unsigned RSW      = sat_pkg::ValueW + CW,
  parameter int unsigned CMD_W    = 2 + 2 * CW + 2 * RW + 2 + RSW
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  input  wire logic [CMD_W-1:0] cmd_i,
  output logic                  cmd_pop_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output sat_pkg::sat_out_t     out_o
);

  import sat_pkg::*;

  localparam int unsigned AW = CW + RW;

  typedef struct packed {
    cmd_op_e        op;
    logic [CW-1:0]  col_a;
    logic [RW-1:0]  row_a;
    logic [CW-1:0]  col_b;
    logic [RW-1:0]  row_b;
    logic           use_col_b;
    logic           use_row_b;
    logic [RSW-1:0] rs;
  } cmd_t;

  logic [SumW-1:0] table_mem [2**AW];
  logic [SumW-1:0] rd_data_q;

  sat_state_e state_q, state_d;
  cmd_t       head;
  cmd_t       cur_q, cur_d;

  logic signed [SumW-1:0] acc_q, acc_d;
  logic                   term_en_q, term_en_d;
  logic                   term_use_q, term_use_d;
  logic                   term_neg_q, term_neg_d;
  logic signed [SumW-1:0] term;
  logic signed [SumW-1:0] total;

  logic            mem_re, mem_we;
  logic [AW-1:0]   mem_addr;
  logic [SumW-1:0] mem_wdata;

  sat_out_t res_q, res_d;
  logic     res_valid_q, res_valid_d;
  logic     res_write;
  logic     can_write;

  assign head      = cmd_t'(cmd_i);
  assign can_write = !res_valid_q || pop_i;
  assign empty_o   = !res_valid_q;
  assign out_o     = res_q;

  assign term  = term_use_q ? $signed(rd_data_q) : '0;
  assign total = term_neg_q ? acc_q - term : acc_q + term;

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    acc_d      = term_en_q ? total : acc_q;
    term_en_d  = 1'b0;
    term_use_d = 1'b0;
    term_neg_d = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = '0;
    mem_wdata  = '0;
    cmd_pop_o  = 1'b0;
    res_write  = 1'b0;
    res_d      = res_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (head.op)
            CMD_LOAD: begin
              cmd_pop_o = 1'b1;
              cur_d     = head;
              mem_re    = head.use_row_b;
              mem_addr  = {head.row_b, head.col_b};
              state_d   = ST_LD_WR;
            end
            CMD_QUERY: begin
              cmd_pop_o  = 1'b1;
              cur_d      = head;
              acc_d      = '0;
              mem_re     = 1'b1;
              mem_addr   = {head.row_a, head.col_a};
              term_en_d  = 1'b1;
              term_use_d = 1'b1;
              state_d    = ST_Q_RD1;
            end
            CMD_EMPTY: begin
              if (can_write) begin
                cmd_pop_o       = 1'b1;
                res_write       = 1'b1;
                res_d.sum       = '0;
                res_d.not_ready = 1'b1;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_LD_WR: begin
        mem_we    = 1'b1;
        mem_addr  = {cur_q.row_a, cur_q.col_a};
        mem_wdata = {{(SumW - RSW){cur_q.rs[RSW-1]}}, cur_q.rs}
                  + (cur_q.use_row_b ? rd_data_q : '0);
        state_d   = ST_IDLE;
      end
      ST_Q_RD1: begin
        mem_re     = 1'b1;
        mem_addr   = {cur_q.row_a, cur_q.col_b};
        term_en_d  = 1'b1;
        term_use_d = cur_q.use_col_b;
        term_neg_d = 1'b1;
        state_d    = ST_Q_RD2;
      end
      ST_Q_RD2: begin
        mem_re     = 1'b1;
        mem_addr   = {cur_q.row_b, cur_q.col_a};
        term_en_d  = 1'b1;
        term_use_d = cur_q.use_row_b;
        term_neg_d = 1'b1;
        state_d    = ST_Q_RD3;
      end
      ST_Q_RD3: begin
        mem_re     = 1'b1;
        mem_addr   = {cur_q.row_b, cur_q.col_b};
        term_en_d  = 1'b1;
        term_use_d = cur_q.use_col_b && cur_q.use_row_b;
        state_d    = ST_Q_SUM;
      end
      ST_Q_SUM: begin
        if (can_write) begin
          res_write       = 1'b1;
          res_d.sum       = total;
          res_d.not_ready = 1'b0;
          state_d         = ST_IDLE;
        end else begin
          state_d = ST_Q_OUT;
        end
      end
      ST_Q_OUT: begin
        if (can_write) begin
          res_write       = 1'b1;
          res_d.sum       = acc_q;
          res_d.not_ready = 1'b0;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_valid_d = res_write ? 1'b1 : (pop_i ? 1'b0 : res_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      term_en_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      term_en_q   <= term_en_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    acc_q      <= acc_d;
    term_use_q <= term_use_d;
    term_neg_q <= term_neg_d;
    res_q      <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= table_mem[mem_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/summed_area_table_rect_sum.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// summed_area_table_rect_sum
// Builds a 2D summed-area table from row-major loads and answers clamped
// inclusive rectangle sums with four table reads.
// ----------------------------------------------------------------------------
//
//  channel   handshake          beat / data
//  --------  -----------------  ---------------------------------------
//  input     push / full        in_i    : sat_in_t  (load or query)
//  result    pop / empty        out_o   : sat_out_t (sum, not_ready)
//  config    cfg_we_i           cfg_idx_i, cfg_data_i (cols, rows)
//
//  A load reads the entry above, then writes its own cell; a query makes four
//  reads of the single-port table plus the final add; a query before a full
//  grid only writes a not_ready result.
//  The front end takes one beat per cycle until the command queue is full.
//  Reset clears all control state; the table itself is not cleared, it only
//  holds meaningful data where loaded since the last reset or config write.
//  A waiting result stalls queries and any loads queued behind a stalled one.
//
module summed_area_table_rect_sum #(
  parameter int unsigned MAX_COLS  = 256,
  parameter int unsigned MAX_ROWS  = 256,
  parameter int unsigned CMD_DEPTH = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input beats
  input  wire logic                        push,
  output logic                             full,
  input  wire sat_pkg::sat_in_t            in_i,
  // result beats
  output logic                             empty,
  input  wire logic                        pop,
  output sat_pkg::sat_out_t                out_o,
  // configuration writes
  input  wire logic                        cfg_we_i,
  input  wire logic [sat_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [sat_pkg::CfgW-1:0]    cfg_data_i
);

  import sat_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned RSW   = ValueW + CW;
  localparam int unsigned CMD_W = 2 + 2 * CW + 2 * RW + 2 + RSW;

  logic             cmd_push;
  logic [CMD_W-1:0] cmd_in;
  logic             cmd_valid;
  logic             cmd_pop;
  logic [CMD_W-1:0] cmd_head;

  // front end: position tracking, running row sum, bound clamping
  sat_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CW       (CW),
    .RW       (RW),
    .RSW      (RSW),
    .CMD_W    (CMD_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // decouples beat intake from table access
  sat_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .valid_o (cmd_valid)
  );

  // back end: table memory, accumulate, result register
  sat_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CW       (CW),
    .RW       (RW),
    .RSW      (RSW),
    .CMD_W    (CMD_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the summed-area table block: streams grid loads and
// rectangle queries through the push/full side, pops sums with random stalls,
// and compares every result beat against an in-bench copy of the table.
// ----------------------------------------------------------------------------
module tb_top;
  import sat_pkg::*;

  localparam int unsigned GRID_COLS     = 256;
  localparam int unsigned GRID_ROWS     = 256;
  localparam int unsigned RANDOM_BEATS  = 1800;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned REPORT_LIMIT  = 10;

  // indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  localparam logic signed [ValueW-1:0] VALUE_MAX = 24'sh7FFFFF;
  localparam logic signed [ValueW-1:0] VALUE_MIN = 24'sh800000;
  localparam logic signed [BoundW-1:0] BOUND_MAX = 16'sh7FFF;
  localparam logic signed [BoundW-1:0] BOUND_MIN = 16'sh8000;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               push       = 1'b0;
  logic               full;
  sat_in_t            in_beat    = '0;
  logic               empty;
  logic               pop        = 1'b0;
  sat_out_t           out_beat;
  logic               cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i  = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;

  // stimulus pacing controls
  bit tx_steady   = 1'b0;
  bit rx_steady   = 1'b0;
  bit rx_holding  = 1'b0;
  event hold_results;

  int unsigned beats_sent  = 0;
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;

  // shadow of the block: registers, load cursor and the table itself
  logic [CfgW-1:0] width_reg  = CFG_COUNT_RST;
  logic [CfgW-1:0] height_reg = CFG_COUNT_RST;
  int unsigned     pos_col    = 0;
  int unsigned     pos_row    = 0;
  longint          row_total  = 0;
  bit              grid_valid = 1'b0;
  longint          area_sums [GRID_COLS*GRID_ROWS];

  sat_out_t expected_sums [$];

  summed_area_table_rect_sum #(
    .MAX_COLS (GRID_COLS),
    .MAX_ROWS (GRID_ROWS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (in_beat),
    .empty      (empty),
    .pop        (pop),
    .out_o      (out_beat),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- shadow model

  function automatic int unsigned used_count(logic [CfgW-1:0] r, int unsigned limit);
    if (r == 0) return 1;
    if (32'(r) > limit) return limit;
    return 32'(r);
  endfunction

  function automatic int unsigned clamp_bound(logic signed [BoundW-1:0] b,
                                              int unsigned count);
    int v;
    v = int'(b);
    if (v < 0) return 0;
    if (v > int'(count) - 1) return count - 1;
    return v;
  endfunction

  function automatic longint area_at(int unsigned col, int unsigned row);
    return area_sums[row*GRID_COLS + col];
  endfunction

  // any write to a real register restarts the grid
  task automatic apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    case (idx)
      CFG_COLS: width_reg = val;
      CFG_ROWS: height_reg = val;
      default: return;
    endcase
    pos_col    = 0;
    pos_row    = 0;
    row_total  = 0;
    grid_valid = 1'b0;
  endtask

  task automatic model_beat(sat_in_t b);
    int unsigned w, h, fc, lc, fr, lr;
    longint      v, s, above;
    sat_out_t    r;
    w = used_count(width_reg, GRID_COLS);
    h = used_count(height_reg, GRID_ROWS);
    if (b.kind == KIND_LOAD) begin
      v = longint'(b.value);
      if (b.start_of_grid) begin
        pos_col = 0;
        pos_row = 0;
      end
      if (pos_col >= w || pos_row >= h) begin
        pos_col = 0;
        pos_row = 0;
      end
      if (pos_col == 0) row_total = 0;
      if (pos_col == 0 && pos_row == 0) grid_valid = 1'b0;
      row_total += v;
      above = (pos_row > 0) ? area_at(pos_col, pos_row - 1) : 0;
      area_sums[pos_row*GRID_COLS + pos_col] = row_total + above;
      pos_col++;
      if (pos_col >= w) begin
        pos_col = 0;
        pos_row++;
        if (pos_row >= h) begin
          pos_row    = 0;
          grid_valid = 1'b1;
        end
      end
      return;
    end
    if (!grid_valid) begin
      r.sum       = '0;
      r.not_ready = 1'b1;
    end else begin
      fc = clamp_bound(b.first_col, w);
      lc = clamp_bound(b.last_col, w);
      fr = clamp_bound(b.first_row, h);
      lr = clamp_bound(b.last_row, h);
      // reversed bounds fall through the same four-corner formula
      s = area_at(lc, lr);
      if (fc > 0) s -= area_at(fc - 1, lr);
      if (fr > 0) s -= area_at(lc, fr - 1);
      if (fc > 0 && fr > 0) s += area_at(fc - 1, fr - 1);
      r.sum       = s[SumW-1:0];
      r.not_ready = 1'b0;
    end
    expected_sums.push_back(r);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_result(sat_out_t got);
    sat_out_t want;
    if (expected_sums.size() == 0) begin
      note_failure($sformatf("unexpected result beat: sum %0d not_ready %0b",
                             got.sum, got.not_ready));
      return;
    end
    want = expected_sums.pop_front();
    if (got.sum !== want.sum)
      note_failure($sformatf("sum: expected %0d got %0d", want.sum, got.sum));
    if (got.not_ready !== want.not_ready)
      note_failure($sformatf("not_ready: expected %0b got %0b",
                             want.not_ready, got.not_ready));
  endtask

  // pre-edge values are sampled here; the block updates after this region
  always @(posedge clk_i) begin : scoreboard
    if (rst_ni) begin
      if (pop && !empty) check_result(out_beat);
      if (push && !full) model_beat(in_beat);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((push && !full) || (pop && !empty) || cfg_we_i) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- result side

  initial begin : hold_timer
    forever begin
      @(hold_results);
      rx_holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      rx_holding = 1'b0;
    end
  end

  always @(posedge clk_i) begin : result_taker
    if (rx_holding) pop <= 1'b0;
    else if (rx_steady) pop <= 1'b1;
    else pop <= ($urandom_range(99) >= 10);
  end

  // ---------------------------------------------------------------- beat builders

  function automatic sat_in_t junk_beat();
    sat_in_t b;
    b.kind          = 1'($urandom_range(1));
    b.start_of_grid = 1'($urandom_range(1));
    b.value         = ValueW'($urandom);
    b.first_col     = BoundW'($urandom);
    b.last_col      = BoundW'($urandom);
    b.first_row     = BoundW'($urandom);
    b.last_row      = BoundW'($urandom);
    return b;
  endfunction

  function automatic sat_in_t load_beat(logic signed [ValueW-1:0] v, logic sof);
    sat_in_t b;
    b               = junk_beat();
    b.kind          = KIND_LOAD;
    b.start_of_grid = sof;
    b.value         = v;
    return b;
  endfunction

  function automatic sat_in_t query_beat(logic signed [BoundW-1:0] fc,
                                         logic signed [BoundW-1:0] lc,
                                         logic signed [BoundW-1:0] fr,
                                         logic signed [BoundW-1:0] lr);
    sat_in_t b;
    b           = junk_beat();
    b.kind      = KIND_QUERY;
    b.first_col = fc;
    b.last_col  = lc;
    b.first_row = fr;
    b.last_row  = lr;
    return b;
  endfunction

  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      default: return ValueW'($urandom);
    endcase
  endfunction

  // mostly in range, some just outside, some anywhere in 16 bits
  function automatic logic signed [BoundW-1:0] pick_bound(int unsigned count);
    int v;
    case ($urandom_range(19))
      0:       v = int'(BOUND_MIN);
      1:       v = int'(BOUND_MAX);
      2, 3:    v = $urandom;
      4, 5, 6: v = int'($urandom_range(0, count + 5)) - 3;
      default: v = $urandom_range(0, count - 1);
    endcase
    return BoundW'(v);
  endfunction

  function automatic sat_in_t random_query(int unsigned w, int unsigned h);
    return query_beat(pick_bound(w), pick_bound(w), pick_bound(h), pick_bound(h));
  endfunction

  // ---------------------------------------------------------------- driving

  // push stays high across back-to-back beats; it only drops for a gap
  task automatic send_beat(sat_in_t b);
    int unsigned gap;
    gap = 0;
    if (!tx_steady)
      while ($urandom_range(99) < 10) gap++;
    if (gap != 0) begin
      push    <= 1'b0;
      in_beat <= junk_beat();
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_beat <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    beats_sent++;
  endtask

  // loads leave no result, so give the back end time to finish them
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    apply_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_grid(logic [CfgW-1:0] cols, logic [CfgW-1:0] rows);
    wait_idle();
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, CfgW'($urandom));
    if ($urandom_range(1)) begin
      write_reg(CFG_ROWS, rows);
      write_reg(CFG_COLS, cols);
    end else begin
      write_reg(CFG_COLS, cols);
      write_reg(CFG_ROWS, rows);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // reset leaves a 256x256 grid with nothing loaded
  task automatic test_query_before_grid();
    send_beat(query_beat(BOUND_MIN, BOUND_MAX, BOUND_MIN, BOUND_MAX));
    send_beat(load_beat(VALUE_MAX, 1'b1));
    send_beat(query_beat(0, 0, 0, 0));
    wait_idle();
  endtask

  // zero counts mean one cell; each load wraps and completes the grid
  task automatic test_single_cell_grid();
    set_grid(9'd0, 9'd0);
    send_beat(load_beat(VALUE_MAX, 1'b1));
    send_beat(query_beat(BOUND_MIN, BOUND_MAX, BOUND_MIN, BOUND_MAX));
    send_beat(query_beat(BOUND_MAX, BOUND_MIN, BOUND_MAX, BOUND_MIN));
    send_beat(load_beat(VALUE_MIN, 1'b0));
    send_beat(query_beat(5, 5, 5, 5));
    wait_idle();
  endtask

  // 2x2: clamping, reversed bounds, ignored index, partial grid, restart
  task automatic test_small_grid();
    set_grid(9'd2, 9'd2);
    send_beat(load_beat(VALUE_MAX, 1'b1));
    send_beat(load_beat(VALUE_MIN, 1'b0));
    send_beat(load_beat(-1, 1'b0));
    send_beat(load_beat(1, 1'b0));
    send_beat(query_beat(0, 1, 0, 1));
    send_beat(query_beat(1, 0, 1, 0));
    send_beat(query_beat(-5, 1, 40, 40));
    wait_idle();
    write_reg(CFG_SPARE_A, 9'h1FF);
    write_reg(CFG_SPARE_B, 9'h000);
    send_beat(query_beat(1, 1, 0, 1));
    send_beat(load_beat(7, 1'b1));
    send_beat(load_beat(3, 1'b0));
    send_beat(query_beat(0, 1, 0, 1));
    repeat (4) send_beat(load_beat(VALUE_MAX, 1'b1));
    wait_idle();
    send_beat(load_beat(VALUE_MAX, 1'b1));
    repeat (3) send_beat(load_beat(VALUE_MAX, 1'b0));
    send_beat(query_beat(0, 1, 0, 1));
    wait_idle();
  endtask

  // receiver stops for a long stretch while queries keep coming
  task automatic test_full_queue_stall();
    tx_steady = 1'b1;
    set_grid(9'd4, 9'd4);
    for (int i = 0; i < 16; i++) send_beat(load_beat(pick_value(), i == 0));
    -> hold_results;
    repeat (24) send_beat(random_query(4, 4));
    wait_idle();
    tx_steady = 1'b0;
  endtask

  // mostly complete grids followed by queries, with stray queries and restarts
  task automatic test_random_phases();
    int unsigned first_beat, phase, w, h, cells, passes;
    logic [CfgW-1:0] cv, rv;
    first_beat = beats_sent;
    phase      = 0;
    while (beats_sent - first_beat < RANDOM_BEATS) begin
      tx_steady = (phase >= 3 && phase < 6);
      rx_steady = (phase >= 3 && phase < 6);
      if (phase == 0) begin
        cv = CfgW'($urandom_range(256, 511));
        rv = CfgW'($urandom_range(0, 1));
      end else if (phase == 1) begin
        cv = 9'd1;
        rv = CfgW'($urandom_range(257, 511));
      end else begin
        case ($urandom_range(31))
          0: begin
            cv = 9'd256;
            rv = 9'd1;
          end
          1: begin
            cv = 9'd0;
            rv = CfgW'($urandom_range(0, 8));
          end
          default: begin
            cv = CfgW'($urandom_range(1, 8));
            rv = CfgW'($urandom_range(1, 8));
          end
        endcase
      end
      set_grid(cv, rv);
      w      = used_count(cv, GRID_COLS);
      h      = used_count(rv, GRID_ROWS);
      cells  = w * h;
      passes = (cells > 64) ? 1 : $urandom_range(1, 3);
      repeat ($urandom_range(0, 1)) send_beat(random_query(w, h));
      repeat (passes) begin
        for (int unsigned c = 0; c < cells; c++) begin
          if ($urandom_range(99) < 4) send_beat(random_query(w, h));
          send_beat(load_beat(pick_value(),
                              (c == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 2)));
        end
        repeat ($urandom_range(3, 10)) send_beat(random_query(w, h));
      end
      phase++;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_idle();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin : run_tests
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_query_before_grid();
    test_single_cell_grid();
    test_small_grid();
    test_full_queue_stall();
    test_random_phases();
    wait_idle();
    if (fail_count == 0 && expected_sums.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
